FILE: rtl/core/deq_pkg.sv
// Shared types, codes and sizes for the double-ended queue.
// Used by deq_cell, deq_ctrl and double_ended_queue; depends on nothing.

package deq_pkg;

    // Sizes. The capacity may range from 2 to 64 entries.
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // What a cell loads in the coming cycle.
    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,  // keep its value
        OP_NEW   = 3'd1,  // take the pushed value
        OP_LEFT  = 3'd2,  // take the neighbour towards the front
        OP_RIGHT = 3'd3,  // take the neighbour towards the rear
        OP_FRONT = 3'd4   // take the front cell (rotation during a listing)
    } t_cell_op;

    // Control handed from the controller to the row of cells.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_cell_op [CAPACITY-1:0]  op;
    } t_chain_ctrl;

endpackage

FILE: rtl/core/double_ended_queue.sv
// Top level of the double-ended queue: a row of deq_cell storage cells with deq_ctrl.
// Depends on deq_pkg, deq_cell and deq_ctrl.
//
//   Channel | Valid       | Ready       | Payload
//   --------+-------------+-------------+-----------------------------
//   request | i_in_valid  | o_in_ready  | i_func, i_value
//   result  | o_out_valid | i_out_ready | o_status, o_data, o_last
//
// Pushes and pops may follow each other in every cycle; a request is taken only when
// the result register is empty or its beat leaves that cycle.
// In a listing the chain rotates once per beat, sending the front cell, and takes no
// request until the final beat has been sent.
// Reset clears the count and the controller; cell contents are not cleared.
// A stalled result beat holds the listing and blocks new requests.

module double_ended_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [deq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [deq_pkg::STAT_W-1:0]        o_status,
    output logic signed [deq_pkg::DATA_W-1:0] o_data,
    output logic                              o_last
);

    logic signed [deq_pkg::DATA_W-1:0] w_cells [deq_pkg::CAPACITY];
    deq_pkg::t_chain_ctrl              w_chain;

    // Controller.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last),
        .i_cells     (w_cells),
        .o_chain     (w_chain)
    );

    // Chain of cells, front at position zero; the ends see themselves as neighbours.
    for (genvar g = 0; g < deq_pkg::CAPACITY; g++) begin : g_cell
        logic signed [deq_pkg::DATA_W-1:0] w_left;
        logic signed [deq_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_cells[g];
        end else begin : g_body
            assign w_left = w_cells[g-1];
        end

        if (g == deq_pkg::CAPACITY - 1) begin : g_tail
            assign w_right = w_cells[g];
        end else begin : g_inner
            assign w_right = w_cells[g+1];
        end

        deq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_chain.op[g]),
            .i_new   (w_chain.value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_front (w_cells[0]),
            .o_value (w_cells[g])
        );
    end

endmodule

FILE: rtl/core/deq_cell.sv
// One storage cell of the deque chain.
// Depends on deq_pkg for the data width and the cell operation codes.

module deq_cell (
    input  logic                              i_clk,
    input  deq_pkg::t_cell_op                 i_op,
    input  logic signed [deq_pkg::DATA_W-1:0] i_new,
    input  logic signed [deq_pkg::DATA_W-1:0] i_left,
    input  logic signed [deq_pkg::DATA_W-1:0] i_right,
    input  logic signed [deq_pkg::DATA_W-1:0] i_front,
    output logic signed [deq_pkg::DATA_W-1:0] o_value
);

    logic signed [deq_pkg::DATA_W-1:0] r_value;
    logic signed [deq_pkg::DATA_W-1:0] n_value;

    // Select the source for this cell's next value.
    always_comb begin
        case (i_op)
            deq_pkg::OP_NEW:   n_value = i_new;
            deq_pkg::OP_LEFT:  n_value = i_left;
            deq_pkg::OP_RIGHT: n_value = i_right;
            deq_pkg::OP_FRONT: n_value = i_front;
            default:           n_value = r_value;
        endcase
    end

    // Payload register; its content is only read once it has been written.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/core/deq_ctrl.sv
// Request decoder, fill count, listing sequencer and result register of the deque.
// Depends on deq_pkg; drives the cell operations of the chain in double_ended_queue.

module deq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [deq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [deq_pkg::STAT_W-1:0]        o_status,
    output logic signed [deq_pkg::DATA_W-1:0] o_data,
    output logic                              o_last,
    input  logic signed [deq_pkg::DATA_W-1:0] i_cells [deq_pkg::CAPACITY],
    output deq_pkg::t_chain_ctrl              o_chain
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } t_state;

    t_state                            r_state,  n_state;
    logic [deq_pkg::CNT_W-1:0]         r_count,  n_count;
    logic [deq_pkg::CNT_W-1:0]         r_left,   n_left;
    logic                              r_out_valid;
    logic [deq_pkg::STAT_W-1:0]        r_status;
    logic signed [deq_pkg::DATA_W-1:0] r_data;
    logic                              r_last;

    logic                              out_free;
    logic                              in_fire;
    logic                              is_empty;
    logic                              is_full;
    logic signed [deq_pkg::DATA_W-1:0] rear_value;
    logic                              emit;
    logic [deq_pkg::STAT_W-1:0]        e_status;
    logic signed [deq_pkg::DATA_W-1:0] e_data;
    logic                              e_last;
    deq_pkg::t_cell_op                 op [deq_pkg::CAPACITY];
    deq_pkg::t_cell_op                 rot_op [deq_pkg::CAPACITY];

    // Handshake: a new request needs the idle state and room in the result register.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == deq_pkg::CNT_W'(deq_pkg::CAPACITY));

    // The rear entry is the one cell whose position is one below the count.
    always_comb begin
        rear_value = '0;
        for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
            if (r_count == deq_pkg::CNT_W'(i + 1)) begin
                rear_value = rear_value | i_cells[i];
            end
        end
    end

    // Rotation for a listing: the front leaves, the rest move up, the front goes to the rear.
    always_comb begin
        for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
            if (deq_pkg::CNT_W'(i + 1) < r_count) begin
                rot_op[i] = deq_pkg::OP_RIGHT;
            end else if (deq_pkg::CNT_W'(i + 1) == r_count) begin
                rot_op[i] = deq_pkg::OP_FRONT;
            end else begin
                rot_op[i] = deq_pkg::OP_HOLD;
            end
        end
    end

    // Request decode and listing sequence.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        emit     = 1'b0;
        e_status = deq_pkg::STAT_OK;
        e_data   = '0;
        e_last   = 1'b1;
        for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
            op[i] = deq_pkg::OP_HOLD;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_func)
                        deq_pkg::FUNC_PUSH_FRONT: begin
                            emit = 1'b1;
                            if (is_full) begin
                                e_status = deq_pkg::STAT_FULL;
                            end else begin
                                op[0] = deq_pkg::OP_NEW;
                                for (int i = 1; i < deq_pkg::CAPACITY; i++) begin
                                    op[i] = deq_pkg::OP_LEFT;
                                end
                                n_count = r_count + deq_pkg::CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_PUSH_REAR: begin
                            emit = 1'b1;
                            if (is_full) begin
                                e_status = deq_pkg::STAT_FULL;
                            end else begin
                                for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
                                    if (r_count == deq_pkg::CNT_W'(i)) begin
                                        op[i] = deq_pkg::OP_NEW;
                                    end
                                end
                                n_count = r_count + deq_pkg::CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_POP_FRONT: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                e_status = deq_pkg::STAT_EMPTY;
                            end else begin
                                e_data = i_cells[0];
                                for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
                                    op[i] = deq_pkg::OP_RIGHT;
                                end
                                n_count = r_count - deq_pkg::CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_POP_REAR: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                e_status = deq_pkg::STAT_EMPTY;
                            end else begin
                                e_data  = rear_value;
                                n_count = r_count - deq_pkg::CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_LIST: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                e_status = deq_pkg::STAT_EMPTY;
                            end else begin
                                e_data = i_cells[0];
                                e_last = (r_count == deq_pkg::CNT_W'(1));
                                op     = rot_op;
                                if (r_count != deq_pkg::CNT_W'(1)) begin
                                    n_state = ST_LIST;
                                    n_left  = r_count - deq_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            // Unused codes are taken and dropped.
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_data = i_cells[0];
                    e_last = (r_left == deq_pkg::CNT_W'(1));
                    op     = rot_op;
                    n_left = r_left - deq_pkg::CNT_W'(1);
                    if (r_left == deq_pkg::CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= e_status;
            r_data   <= e_data;
            r_last   <= e_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_last      = r_last;

    // Cell controls towards the chain.
    always_comb begin
        o_chain.value = i_value;
        for (int i = 0; i < deq_pkg::CAPACITY; i++) begin
            o_chain.op[i] = op[i];
        end
    end

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
        else $error("deque count above capacity");

    // A listing in progress always has entries left to send and holds off requests.
    a_list_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> (r_left != '0) && !o_in_ready)
        else $error("listing state without entries left");

    // A push that fits raises the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !is_full && (i_func == deq_pkg::FUNC_PUSH_FRONT ||
         i_func == deq_pkg::FUNC_PUSH_REAR))
        |=> (r_count == $past(r_count) + deq_pkg::CNT_W'(1)))
        else $error("push did not raise the count");

    // A pop from a non-empty deque lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !is_empty && (i_func == deq_pkg::FUNC_POP_FRONT ||
         i_func == deq_pkg::FUNC_POP_REAR))
        |=> (r_count == $past(r_count) - deq_pkg::CNT_W'(1)))
        else $error("pop did not lower the count");

    // A listing leaves the count alone.
    a_list_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |=> $stable(r_count))
        else $error("count changed during a listing");

endmodule
